@@ rtl/numeric_string_recognizer_core_defines.svh @@
// Assertion macros for the numeric string recognizer core.
// No dependencies; expects signals named clock and reset at the point of use.
`ifndef NUMERIC_STRING_RECOGNIZER_CORE_DEFINES_SVH
`define NUMERIC_STRING_RECOGNIZER_CORE_DEFINES_SVH

// same-cycle implication, disabled during reset
`define NSR_ASSERT_NOW(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("nsr: same-cycle check failed");

// next-cycle implication, disabled during reset
`define NSR_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("nsr: next-cycle check failed");

`endif

@@ rtl/nsr_pkg.sv @@
// Package for the numeric string recognizer: state codes, character codes, word types.
// No dependencies.
`timescale 1ns / 1ps

package nsr_pkg;

   typedef enum logic [3:0] {
      ST_INIT    = 4'd0,
      ST_SIGN    = 4'd1,
      ST_FIRST   = 4'd2,
      ST_DIGITS  = 4'd3,
      ST_DOT     = 4'd4,
      ST_FRAC    = 4'd5,
      ST_EMARK   = 4'd6,
      ST_ESIGN   = 4'd7,
      ST_EFIRST  = 4'd8,
      ST_EDIGITS = 4'd9,
      ST_TRAIL   = 4'd10,
      ST_REJECT  = 4'd11
   } state_type;

   localparam logic [7:0] CHAR_SPACE = 8'h20;
   localparam logic [7:0] CHAR_PLUS  = 8'h2B;
   localparam logic [7:0] CHAR_MINUS = 8'h2D;
   localparam logic [7:0] CHAR_DOT   = 8'h2E;
   localparam logic [7:0] CHAR_ZERO  = 8'h30;
   localparam logic [7:0] CHAR_NINE  = 8'h39;
   localparam logic [7:0] CHAR_UPPER_E = 8'h45;
   localparam logic [7:0] CHAR_LOWER_E = 8'h65;

   typedef struct packed {
      logic [7:0] char_code;
      logic       last_char;
      logic       empty_string;
   } item_type;

   typedef struct packed {
      logic emit;
      logic is_numeric;
   } step_type;

endpackage

@@ rtl/numeric_string_recognizer_core.sv @@
// Numeric string recogniser top level: request register, state machine, response register.
// Depends on nsr_pkg, nsr_in_reg, nsr_fsm and numeric_string_recognizer_core_defines.svh.
//
// Usage:
//   Request channel (req_valid/req_ready) takes one character word per cycle while
//   req_ready is high: req_char_code, req_last_char marking the final character, and
//   req_empty_string marking a zero-length string (character ignored).
//   Response channel (rsp_valid/rsp_ready) gives one word per string,
//   rsp_is_numeric, when the last character or an empty-string word is seen.
//   The final word of a string lands in the request register; its verdict is then
//   registered in the response register once any earlier response has been taken.
//   The request register passes one word per cycle through the state transition to
//   the state register, but a string end waits there while a response is pending.
//   Reset (synchronous, active high) empties both registers and returns the
//   recogniser to its initial state.
//   When the receiver stalls, the pending response holds; middle characters
//   keep flowing, and a second string end waits in the request register, so
//   req_ready drops only once that register is also blocked.
`timescale 1ns / 1ps
`include "numeric_string_recognizer_core_defines.svh"

module numeric_string_recognizer_core (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [7:0] req_char_code,
   input  logic       req_last_char,
   input  logic       req_empty_string,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic       rsp_is_numeric
);
   import nsr_pkg::*;

   item_type  req_item, in_item;
   step_type  step;
   state_type parse_state;
   logic      in_valid, advance;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      rsp_is_numeric_ff, rsp_is_numeric_in;
   logic      rsp_load;

   assign req_item.char_code    = req_char_code;
   assign req_item.last_char    = req_last_char;
   assign req_item.empty_string = req_empty_string;

   nsr_in_reg u_in_reg (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_item  (req_item),
      .advance   (advance),
      .in_valid  (in_valid),
      .in_item   (in_item)
   );

   nsr_fsm u_fsm (
      .clock       (clock),
      .reset       (reset),
      .item        (in_item),
      .advance     (advance),
      .step        (step),
      .parse_state (parse_state)
   );

   assign advance  = in_valid && (!step.emit || !rsp_valid_ff || rsp_ready);
   assign rsp_load = advance && step.emit;

   always_comb begin
      rsp_valid_in      = rsp_valid_ff;
      rsp_is_numeric_in = rsp_is_numeric_ff;
      if (rsp_load) begin
         rsp_valid_in      = 1'b1;
         rsp_is_numeric_in = step.is_numeric;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_is_numeric_ff <= rsp_is_numeric_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_is_numeric = rsp_is_numeric_ff;

   `NSR_ASSERT_NEXT(a_empty_rejects, advance && in_item.empty_string, rsp_valid && !rsp_is_numeric)
   `NSR_ASSERT_NEXT(a_end_resets_state, advance && step.emit, parse_state == ST_INIT)
   `NSR_ASSERT_NOW(a_no_overwrite, in_valid && step.emit && rsp_valid && !rsp_ready, !advance)

endmodule

@@ rtl/nsr_in_reg.sv @@
// Input register stage of the numeric string recognizer: holds one request word.
// Depends on nsr_pkg.
`timescale 1ns / 1ps

module nsr_in_reg (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  nsr_pkg::item_type req_item,
   input  logic              advance,
   output logic              in_valid,
   output nsr_pkg::item_type in_item
);
   import nsr_pkg::*;

   logic     in_valid_ff, in_valid_in;
   item_type item_ff, item_in;
   logic     load;

   assign req_ready = !in_valid_ff || advance;
   assign load      = req_valid && req_ready;

   always_comb begin
      in_valid_in = in_valid_ff;
      item_in     = item_ff;
      if (load) begin
         in_valid_in = 1'b1;
         item_in     = req_item;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      item_ff <= item_in;
   end

   assign in_valid = in_valid_ff;
   assign in_item  = item_ff;

endmodule

@@ rtl/nsr_fsm.sv @@
// Recogniser state machine: parse state register, transition and result logic.
// Depends on nsr_pkg.
`timescale 1ns / 1ps

module nsr_fsm (
   input  logic               clock,
   input  logic               reset,
   input  nsr_pkg::item_type  item,
   input  logic               advance,
   output nsr_pkg::step_type  step,
   output nsr_pkg::state_type parse_state
);
   import nsr_pkg::*;

   state_type state_ff, state_in, ns;
   logic      dig, spc, sgn, dot, exm;

   always_comb begin
      dig = (item.char_code >= CHAR_ZERO) && (item.char_code <= CHAR_NINE);
      spc = (item.char_code == CHAR_SPACE);
      sgn = (item.char_code == CHAR_PLUS) || (item.char_code == CHAR_MINUS);
      dot = (item.char_code == CHAR_DOT);
      exm = (item.char_code == CHAR_LOWER_E) || (item.char_code == CHAR_UPPER_E);
   end

   // next state
   always_comb begin
      ns = ST_REJECT;
      case (state_ff)
         ST_INIT: begin
            if (spc)      ns = ST_INIT;
            else if (dig) ns = ST_FIRST;
            else if (sgn) ns = ST_SIGN;
         end
         ST_SIGN: begin
            if (dig)      ns = ST_FIRST;
            else if (spc) ns = ST_TRAIL;
         end
         ST_FIRST, ST_DIGITS: begin
            if (dig)      ns = ST_DIGITS;
            else if (dot) ns = ST_DOT;
            else if (spc) ns = ST_TRAIL;
            else if (exm) ns = ST_EMARK;
         end
         ST_DOT: begin
            if (dig) ns = ST_FRAC;
         end
         ST_FRAC: begin
            if (dig)      ns = ST_FRAC;
            else if (spc) ns = ST_TRAIL;
            else if (exm) ns = ST_EMARK;
         end
         ST_EMARK: begin
            if (dig)      ns = ST_EFIRST;
            else if (sgn) ns = ST_ESIGN;
         end
         ST_ESIGN: begin
            if (dig) ns = ST_EFIRST;
         end
         ST_EFIRST, ST_EDIGITS: begin
            if (dig)      ns = ST_EDIGITS;
            else if (spc) ns = ST_TRAIL;
         end
         ST_TRAIL: begin
            if (spc) ns = ST_TRAIL;
         end
         default: begin
            ns = ST_REJECT;
         end
      endcase

      state_in = state_ff;
      if (advance) begin
         if (item.empty_string || item.last_char) state_in = ST_INIT;
         else                                     state_in = ns;
      end
   end

   // outputs
   always_comb begin
      step.emit = item.empty_string || item.last_char;
      case (ns)
         ST_FIRST, ST_DIGITS, ST_FRAC, ST_EFIRST, ST_EDIGITS, ST_TRAIL: begin
            step.is_numeric = !item.empty_string;
         end
         default: begin
            step.is_numeric = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_INIT;
      end else begin
         state_ff <= state_in;
      end
   end

   assign parse_state = state_ff;

endmodule
